### src/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// Shared widths, constants and control types of the scalar Kalman sample
// filter: fixed-point formats, reset values and the controller interface.
// ----------------------------------------------------------------------------
package skf_pkg;

    // Fixed-point formats.
    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 30;
    localparam int EST_W         = 32;
    localparam int EST_FRAC      = EST_W - SAMPLE_BITS;
    localparam int VAR_W         = 31;
    localparam int PRED_W        = VAR_W + 1;
    localparam int DEN_W         = PRED_W + 1;
    localparam int REM_W         = PRED_W + 2;
    localparam int GAIN_W        = FRACTION_BITS + 1;
    localparam int MUL_B_W       = (EST_W > PRED_W) ? EST_W : PRED_W;
    localparam int PROD_W        = GAIN_W + MUL_B_W;
    localparam int NV_W          = PROD_W - FRACTION_BITS;

    // Divider sequencing: one integer quotient bit plus the fraction bits.
    localparam int DIV_STEPS = FRACTION_BITS + 1;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // Configuration registers.
    localparam int REG_W   = 31;
    localparam int INDEX_W = 2;
    localparam logic [INDEX_W-1:0] REG_PROCESS_NOISE     = INDEX_W'(0);
    localparam logic [INDEX_W-1:0] REG_MEASUREMENT_NOISE = INDEX_W'(1);
    localparam logic [REG_W-1:0]   Q_RESET = REG_W'(107374);
    localparam logic [REG_W-1:0]   R_RESET = REG_W'(5368709);

    localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [VAR_W-1:0]  VAR_MAX  = {VAR_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL_GAIN,
        S_MUL_VAR,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic div_first;
        logic mul_gain;
        logic mul_var;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_busy;
    } t_dp_status;

endpackage

### src/skf_ctrl.sv
// ----------------------------------------------------------------------------
// skf_ctrl
// Sequencer of the filter: takes a word, steps the divider through all
// quotient bits, runs the two shared multiplies and hands off the result.
// ----------------------------------------------------------------------------
module skf_ctrl
    import skf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;

    // State and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Next state and datapath commands. No word is taken while in reset.
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_count    = '0;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_first = (r_count == '0);
                n_count         = r_count + CNT_W'(1);
                if (r_count == DIV_LAST) begin
                    n_state = S_MUL_GAIN;
                end
            end
            S_MUL_GAIN: begin
                o_cmd.mul_gain = 1'b1;
                n_state        = S_MUL_VAR;
            end
            S_MUL_VAR: begin
                o_cmd.mul_var = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The divider always runs its full count before the first multiply.
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_GAIN) |-> ($past(r_state) == S_DIV && $past(r_count) == DIV_LAST))
        else $error("multiply started before the divider finished");

    // The variance multiply follows the gain multiply directly.
    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mul_gain |=> o_cmd.mul_var)
        else $error("variance multiply did not follow gain multiply");

    // A load always starts the divider at step zero; loads come only from idle.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DIV && r_count == '0))
        else $error("load did not start the divider at step zero");

endmodule

### src/skf_datapath.sv
// ----------------------------------------------------------------------------
// skf_datapath
// Filter state, configuration registers, restoring divider for the gain,
// one shared multiplier and the output register.
// ----------------------------------------------------------------------------
module skf_datapath
    import skf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [INDEX_W-1:0]     i_wr_index,
    input  logic [REG_W-1:0]       i_wr_data,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [SAMPLE_BITS-1:0] o_filtered
);

    logic [REG_W-1:0]       r_q;
    logic [REG_W-1:0]       r_r;
    logic [EST_W-1:0]       r_est;
    logic [VAR_W-1:0]       r_var;
    logic [PRED_W-1:0]      r_pred;
    logic [DEN_W-1:0]       r_den;
    logic                   r_den_zero;
    logic [REM_W-1:0]       r_rem;
    logic [GAIN_W-1:0]      r_quo;
    logic [EST_W-1:0]       r_mag;
    logic                   r_neg;
    logic [PROD_W-1:0]      r_prod;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_data;

    logic [EST_W-1:0]   w_target;
    logic [PRED_W-1:0]  w_pred;
    logic [DEN_W-1:0]   w_den;
    logic [REM_W-1:0]   w_shift;
    logic [REM_W-1:0]   w_den_ext;
    logic               w_fits;
    logic [GAIN_W-1:0]  w_gain;
    logic [GAIN_W-1:0]  w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [EST_W-1:0]   w_corr;
    logic [NV_W-1:0]    w_var_full;
    logic [VAR_W-1:0]   w_var_sat;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= Q_RESET;
            r_r <= R_RESET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_PROCESS_NOISE:     r_q <= i_wr_data;
                REG_MEASUREMENT_NOISE: r_r <= i_wr_data;
                default: begin
                end
            endcase
        end
    end

    // Prediction, denominator and error magnitude at load time.
    assign w_target = {i_sample, {EST_FRAC{1'b0}}};
    assign w_pred   = PRED_W'(r_var) + PRED_W'(r_q);
    assign w_den    = DEN_W'(w_pred) + DEN_W'(r_r);

    // One restoring step: shift except on the integer bit, then trial subtract.
    assign w_shift   = i_cmd.div_first ? r_rem : {r_rem[REM_W-2:0], 1'b0};
    assign w_den_ext = REM_W'(r_den);
    assign w_fits    = (w_shift >= w_den_ext);

    // Gain is zero on a zero denominator and never above one.
    always_comb begin
        if (r_den_zero) begin
            w_gain = '0;
        end else if (r_quo > GAIN_ONE) begin
            w_gain = GAIN_ONE;
        end else begin
            w_gain = r_quo;
        end
    end

    // Operand selection for the shared multiplier.
    assign w_mul_a = i_cmd.mul_var ? (GAIN_ONE - w_gain) : w_gain;
    assign w_mul_b = i_cmd.mul_var ? MUL_B_W'(r_pred) : MUL_B_W'(r_mag);

    // Correction and saturated variance from the registered product.
    assign w_corr     = r_prod[FRACTION_BITS +: EST_W];
    assign w_var_full = r_prod[PROD_W-1:FRACTION_BITS];
    assign w_var_sat  = (w_var_full > NV_W'(VAR_MAX)) ? VAR_MAX : w_var_full[VAR_W-1:0];

    // Working registers of one word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pred     <= w_pred;
            r_den      <= w_den;
            r_den_zero <= (w_den == '0);
            r_rem      <= REM_W'(w_pred);
            r_quo      <= '0;
            if (w_target >= r_est) begin
                r_mag <= w_target - r_est;
                r_neg <= 1'b0;
            end else begin
                r_mag <= r_est - w_target;
                r_neg <= 1'b1;
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= w_fits ? (w_shift - w_den_ext) : w_shift;
            r_quo <= {r_quo[GAIN_W-2:0], w_fits};
        end
        if (i_cmd.mul_gain || i_cmd.mul_var) begin
            r_prod <= PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
        end
        if (i_cmd.finish) begin
            r_out_data <= r_est[EST_W-1 -: SAMPLE_BITS];
        end
    end

    // Filter state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
            r_var <= '0;
        end else begin
            if (i_cmd.mul_var) begin
                r_est <= r_neg ? (r_est - w_corr) : (r_est + w_corr);
            end
            if (i_cmd.finish) begin
                r_var <= w_var_sat;
            end
        end
    end

    // Output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_filtered        = r_out_data;

    // The remainder stays below the divisor after every step.
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.div_step && !r_den_zero) |=> (r_rem < REM_W'(r_den)))
        else $error("divider remainder not below divisor");

    // The quotient never exceeds one when the multiplies start.
    a_gain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mul_gain && !r_den_zero) |-> (r_quo <= GAIN_ONE))
        else $error("gain quotient above one");

    // The estimate only moves in the update cycle.
    a_est_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.mul_var |=> $stable(r_est))
        else $error("estimate changed outside its update cycle");

    // A new output word only appears after a finish command.
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.finish))
        else $error("output word without a finished update");

endmodule

### src/scalar_kalman_sample_filter.sv
// Sequence per word: the accept, the bit-per-cycle gain divider through all
// of its quotient bits, then the two multiplies on the shared multiplier and
// the write-back. A new word is accepted only after the write-back. A held
// output word delays the write-back until it leaves.
// Reset (synchronous, active low) clears the estimate and variance to zero and
// loads the default process and measurement noise values.
// ----------------------------------------------------------------------------
// scalar_kalman_sample_filter
// One-channel scalar Kalman filter over unsigned converter samples, built
// as a sequencer driving a divider and multiplier datapath.
// ----------------------------------------------------------------------------
module scalar_kalman_sample_filter
    import skf_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr_en,
    input  logic [INDEX_W-1:0]     i_wr_index,
    input  logic [REG_W-1:0]       i_wr_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [SAMPLE_BITS-1:0] o_filtered
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencer.
    skf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and state.
    skf_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (i_wr_en),
        .i_wr_index  (i_wr_index),
        .i_wr_data   (i_wr_data),
        .i_sample    (i_sample),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_filtered  (o_filtered)
    );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the scalar Kalman sample filter against a bit-exact fixed-point
// predictor. A directed table covers reset behavior, sample extremes, zero
// measurement noise, the zero-denominator hold, noise register extremes and
// writes to unused register indexes. Random phases with fresh noise settings,
// random handshake gaps and one long output stall follow.
// ----------------------------------------------------------------------------
module testbench;
    import skf_pkg::*;

    localparam logic [INDEX_W-1:0] REG_SPARE     = INDEX_W'(2);
    localparam logic [INDEX_W-1:0] REG_SPARE_TOP = INDEX_W'(3);
    localparam logic [REG_W-1:0]   NOISE_MAX     = {REG_W{1'b1}};
    localparam logic [63:0]        ONE_FIX       = 64'd1 << FRACTION_BITS;
    localparam int N_DIRECTED    = 28;
    localparam int N_PHASES      = 9;
    localparam int PHASE_SAMPLES = 210;
    localparam int HOLD_CYCLES   = 300;

    // One row of the directed table: a register write or a sample.
    typedef struct packed {
        logic                   is_write;
        logic [INDEX_W-1:0]     index;
        logic [REG_W-1:0]       data;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   typed;
        logic [SAMPLE_BITS-1:0] want;
    } t_step;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_wr_en      = 1'b0;
    logic [INDEX_W-1:0]     i_wr_index   = '0;
    logic [REG_W-1:0]       i_wr_data    = '0;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_ready;
    logic [SAMPLE_BITS-1:0] i_sample     = '0;
    logic                   o_out_valid;
    logic                   i_out_ready  = 1'b0;
    logic [SAMPLE_BITS-1:0] o_filtered;

    // Predictor state and its copy of the noise registers.
    logic [EST_W-1:0] filt_estimate = '0;
    logic [VAR_W-1:0] filt_variance = '0;
    logic [REG_W-1:0] filt_q        = Q_RESET;
    logic [REG_W-1:0] filt_r        = R_RESET;

    logic [SAMPLE_BITS-1:0] pending_filtered [$];
    logic [SAMPLE_BITS-1:0] want_word;
    int  mismatches = 0;
    bit  tx_idle_on = 1'b0;
    bit  rx_idle_on = 1'b0;
    bit  long_hold  = 1'b0;

    t_step directed_steps [0:N_DIRECTED-1] = '{
        '{1'b0, REG_SPARE, '0, 12'h000, 1'b1, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'hFFF, 1'b0, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'h000, 1'b0, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'hAAA, 1'b0, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'h555, 1'b0, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'h800, 1'b0, 12'h000},
        // Writes to indexes past the register list must change nothing.
        '{1'b1, REG_SPARE, NOISE_MAX, 12'h000, 1'b0, 12'h000},
        '{1'b1, REG_SPARE_TOP, '0, 12'h000, 1'b0, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'h7FF, 1'b0, 12'h000},
        // Zero measurement noise: unity gain, the estimate jumps to the sample.
        '{1'b1, REG_MEASUREMENT_NOISE, '0, 12'h000, 1'b0, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'hFFF, 1'b1, 12'hFFF},
        '{1'b0, REG_SPARE, '0, 12'h000, 1'b1, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'hA5A, 1'b1, 12'hA5A},
        // Both noises zero with zero variance: zero denominator, estimate held.
        '{1'b1, REG_PROCESS_NOISE, '0, 12'h000, 1'b0, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'hFFF, 1'b1, 12'hA5A},
        '{1'b0, REG_SPARE, '0, 12'h001, 1'b1, 12'hA5A},
        // Largest noise values.
        '{1'b1, REG_PROCESS_NOISE, NOISE_MAX, 12'h000, 1'b0, 12'h000},
        '{1'b1, REG_MEASUREMENT_NOISE, NOISE_MAX, 12'h000, 1'b0, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'hFFF, 1'b0, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'h000, 1'b0, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'hFFF, 1'b0, 12'h000},
        // No process noise and the smallest nonzero measurement noise.
        '{1'b1, REG_PROCESS_NOISE, '0, 12'h000, 1'b0, 12'h000},
        '{1'b1, REG_MEASUREMENT_NOISE, REG_W'(1), 12'h000, 1'b0, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'h000, 1'b0, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'h123, 1'b0, 12'h000},
        '{1'b0, REG_SPARE, '0, 12'hFFF, 1'b0, 12'h000},
        '{1'b1, REG_PROCESS_NOISE, Q_RESET, 12'h000, 1'b0, 12'h000},
        '{1'b1, REG_MEASUREMENT_NOISE, R_RESET, 12'h000, 1'b0, 12'h000}
    };

    scalar_kalman_sample_filter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (i_wr_en),
        .i_wr_index  (i_wr_index),
        .i_wr_data   (i_wr_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_filtered  (o_filtered)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Runs one filter update on the predictor state and returns the new
    // integer part of the estimate.
    function automatic logic [SAMPLE_BITS-1:0] advance_filter(
        input logic [SAMPLE_BITS-1:0] smp);
        logic [63:0] pred;
        logic [63:0] den;
        logic [63:0] gain;
        logic [63:0] rem;
        logic [63:0] target;
        logic [63:0] corr;
        logic [63:0] new_var;
        pred   = 64'(filt_variance) + 64'(filt_q);
        den    = pred + 64'(filt_r);
        gain   = '0;
        target = 64'(smp) << EST_FRAC;
        // Restoring division: one integer quotient bit, then the fraction.
        if (den != 0) begin
            rem = pred;
            if (rem >= den) begin
                rem  = rem - den;
                gain = 64'd1;
            end
            for (int b = 0; b < FRACTION_BITS; b++) begin
                rem  = rem << 1;
                gain = gain << 1;
                if (rem >= den) begin
                    rem  = rem - den;
                    gain = gain | 64'd1;
                end
            end
        end
        if (gain > ONE_FIX) begin
            gain = ONE_FIX;
        end
        // The correction is truncated toward zero on either side.
        if (target >= 64'(filt_estimate)) begin
            corr = (gain * (target - 64'(filt_estimate))) >> FRACTION_BITS;
            filt_estimate = filt_estimate + EST_W'(corr);
        end else begin
            corr = (gain * (64'(filt_estimate) - target)) >> FRACTION_BITS;
            filt_estimate = filt_estimate - EST_W'(corr);
        end
        new_var = ((ONE_FIX - gain) * pred) >> FRACTION_BITS;
        if (new_var > 64'(VAR_MAX)) begin
            new_var = 64'(VAR_MAX);
        end
        filt_variance = VAR_W'(new_var);
        return filt_estimate[EST_W-1:EST_FRAC];
    endfunction

    // A noise value drawn from the extremes, small, mid-range and full range.
    function automatic logic [REG_W-1:0] pick_noise();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return NOISE_MAX;
            2: return REG_W'($urandom_range(1, 255));
            3: return REG_W'($urandom_range(1000, 10_000_000));
            4: return REG_W'(1);
            default: return REG_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("ERROR %0t: %s", $time, msg);
    endtask

    // Offers one sample word and returns once it is accepted. A typed value,
    // where given, replaces the predicted one as the expected word.
    task automatic offer_sample(input logic [SAMPLE_BITS-1:0] smp,
                                input logic typed,
                                input logic [SAMPLE_BITS-1:0] want);
        int gap;
        logic [SAMPLE_BITS-1:0] predicted;
        gap = tx_idle_on ? $urandom_range(0, 14) : 0;
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= smp;
        predicted = advance_filter(smp);
        pending_filtered.push_back(typed ? want : predicted);
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Waits until every expected word has arrived, then writes one register.
    task automatic write_noise_reg(input logic [INDEX_W-1:0] index,
                                   input logic [REG_W-1:0] data);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_filtered.size() != 0) @(posedge i_clk);
        repeat (3) @(negedge i_clk);
        i_wr_en    <= 1'b1;
        i_wr_index <= index;
        i_wr_data  <= data;
        if (index == REG_PROCESS_NOISE) begin
            filt_q = data;
        end else if (index == REG_MEASUREMENT_NOISE) begin
            filt_r = data;
        end
        @(negedge i_clk);
        i_wr_en <= 1'b0;
    endtask

    // Output side: a random stall before each word where enabled, and one long hold-off
    // when asked for, so that the filter backs up into its input.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                long_hold = 1'b0;
            end
            stall = rx_idle_on ? $urandom_range(0, 14) : 0;
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Compare each accepted word with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_filtered.size() == 0) begin
                report_mismatch($sformatf("unexpected word, filtered=%0d", o_filtered));
            end else begin
                want_word = pending_filtered.pop_front();
                if (o_filtered !== want_word) begin
                    report_mismatch($sformatf("filtered=%0d, expected %0d",
                                              o_filtered, want_word));
                end
            end
        end
    end

    // Stimulus: directed table, then random phases with fresh noise settings.
    initial begin
        int level;
        int value;
        logic [SAMPLE_BITS-1:0] smp;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIRECTED; k++) begin
            if (directed_steps[k].is_write) begin
                write_noise_reg(directed_steps[k].index, directed_steps[k].data);
            end else begin
                offer_sample(directed_steps[k].sample, directed_steps[k].typed,
                             directed_steps[k].want);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            // The first phase keeps the default noise and runs without gaps.
            if (p != 0) begin
                write_noise_reg(REG_PROCESS_NOISE, pick_noise());
                write_noise_reg(REG_MEASUREMENT_NOISE, pick_noise());
            end
            tx_idle_on = (p != 0) && ($urandom_range(0, 3) != 0);
            rx_idle_on = (p != 0) && ($urandom_range(0, 3) != 0);
            if (p == 3) begin
                tx_idle_on = 1'b0;
                long_hold  = 1'b1;
            end
            level = $urandom_range(0, 4095);
            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                case ($urandom_range(0, 9))
                    6: smp = SAMPLE_BITS'($urandom);
                    7: smp = $urandom_range(0, 1) ? '1 : '0;
                    8: begin
                        level = $urandom_range(0, 4095);
                        smp   = SAMPLE_BITS'(level);
                    end
                    default: begin
                        // A steady level with converter noise around it.
                        value = level + int'($urandom_range(0, 64)) - 32;
                        if (value < 0) value = 0;
                        if (value > 4095) value = 4095;
                        smp = SAMPLE_BITS'(value);
                    end
                endcase
                offer_sample(smp, 1'b0, '0);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_filtered.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS scalar_kalman_sample_filter");
        end else begin
            $display("FAIL scalar_kalman_sample_filter");
        end
        $finish;
    end

    // Run limit, several times the slowest correct run.
    initial begin
        #10_000_000;
        $display("FAIL scalar_kalman_sample_filter");
        $finish;
    end

endmodule
